// ===== hw/rtl/vertex_rotate_project_core_macros.svh =====
// Assertion macros for the vertex rotate and project core.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef VERTEX_ROTATE_PROJECT_CORE_MACROS_SVH
`define VERTEX_ROTATE_PROJECT_CORE_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define VRP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after the antecedent.
`define VRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/vrp_pkg.sv =====
// Shared types, constants and helpers for the vertex rotate and project core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vrp_pkg;

    localparam int ANGLE_BITS_DEF = 12;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUOT_BITS      = 16;

    localparam logic [2:0] CFG_ANGLE_X  = 3'd0;
    localparam logic [2:0] CFG_ANGLE_Y  = 3'd1;
    localparam logic [2:0] CFG_ANGLE_Z  = 3'd2;
    localparam logic [2:0] CFG_OFFSET_X = 3'd3;
    localparam logic [2:0] CFG_OFFSET_Y = 3'd4;
    localparam logic [2:0] CFG_DEPTH    = 3'd5;

    localparam logic OP_VERTEX = 1'b0;
    localparam logic OP_NORMAL = 1'b1;

    localparam logic signed [16:0] RECENTRE   = 17'sd384;
    localparam logic signed [20:0] PERSP_Q88  = 21'sd204800;
    localparam logic signed [20:0] MIN_DEPTH  = 21'sd26;
    localparam logic signed [22:0] PROJ_SCALE = 23'sd1638400;
    localparam logic signed [19:0] CENTRE_X   = 20'sd50;
    localparam logic signed [19:0] CENTRE_Y   = 20'sd20;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic signed [15:0] point_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic signed [15:0] rotated_depth;
        logic               facing;
    } t_out;

    typedef struct packed {
        logic               op;
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic signed [16:0] z;
    } t_item;

    typedef struct packed {
        logic signed [15:0] sin_x;
        logic signed [15:0] cos_x;
        logic signed [15:0] sin_y;
        logic signed [15:0] cos_y;
        logic signed [15:0] sin_z;
        logic signed [15:0] cos_z;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic signed [15:0] depth;
    } t_cfg;

    typedef struct packed {
        logic       full;
        logic [1:0] count;
    } t_qstat;

    function automatic logic [14:0] f_sin_entry(input int idx, input int qbits);
        real a;
        a = 1.5707963267948966 * real'(idx);
        for (int i = 0; i < qbits; i++) begin
            a = a * 0.5;
        end
        return 15'($rtoi(32767.0 * $sin(a) + 0.5));
    endfunction

    function automatic logic signed [15:0] f_sat16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/vertex_rotate_project_core.sv =====
// Top level of the vertex rotate and project core: config registers, sine lookup.
// Depends on vrp_pkg, vrp_front, vrp_queue, vrp_back and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_rotate_project_core_macros.svh"
// Takes one point per clock: a start beat is accepted whenever busy is low,
// and busy stays low in steady use because the pipeline drains every cycle.
// Each result appears on o_res with o_res_valid for one cycle, in the order of
// the start beats; the receiver cannot stall it.
// The pipeline runs through the three rotation multiply stages, the projection
// stages and the 16-stage restoring divider. Angle writes read the sine
// table through a registered lookup, so new angles reach the config registers
// by way of the lookup register; offset and depth writes go straight into them.
module vertex_rotate_project_core import vrp_pkg::*; #(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire t_in         i_cmd,
    output logic             o_res_valid,
    output t_out             o_res,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    localparam int QUARTER = 1 << (ANGLE_BITS - 2);

    typedef logic [14:0] t_sin_tab [0:QUARTER];

    function automatic t_sin_tab f_build();
        t_sin_tab t;
        for (int i = 0; i <= QUARTER; i++) begin
            t[i] = f_sin_entry(i, ANGLE_BITS - 2);
        end
        return t;
    endfunction

    localparam t_sin_tab SIN_TAB = f_build();

    function automatic logic [ANGLE_BITS-2:0] f_addr(input logic [ANGLE_BITS-1:0] k);
        logic [ANGLE_BITS-2:0] r;
        r = {1'b0, k[ANGLE_BITS-3:0]};
        if (k[ANGLE_BITS-2]) begin
            r = (ANGLE_BITS-1)'(QUARTER) - r;
        end
        return r;
    endfunction

    t_cfg                  r_cfg;
    logic [ANGLE_BITS-1:0] wr_ang, wr_ang_c;
    logic [ANGLE_BITS-2:0] addr_s, addr_c;
    logic                  cfg_wr, ang_wr;
    logic                  r_lk_valid;
    logic [2:0]            r_lk_index;
    logic                  r_lk_neg_s, r_lk_neg_c;
    logic [14:0]           r_lk_sin, r_lk_cos;
    logic signed [15:0]    lk_sin, lk_cos;
    logic                  push, q_valid;
    t_item                 f_item, q_item;
    t_qstat                q_stat;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;
    assign wr_ang      = i_cfg_data[ANGLE_BITS-1:0];
    assign wr_ang_c    = wr_ang + ANGLE_BITS'(QUARTER);
    assign addr_s      = f_addr(wr_ang);
    assign addr_c      = f_addr(wr_ang_c);
    assign ang_wr      = cfg_wr & ((i_cfg_index == CFG_ANGLE_X) |
                                   (i_cfg_index == CFG_ANGLE_Y) |
                                   (i_cfg_index == CFG_ANGLE_Z));
    assign lk_sin = r_lk_neg_s ? -$signed({1'b0, r_lk_sin}) : $signed({1'b0, r_lk_sin});
    assign lk_cos = r_lk_neg_c ? -$signed({1'b0, r_lk_cos}) : $signed({1'b0, r_lk_cos});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lk_valid <= 1'b0;
        end else begin
            r_lk_valid <= ang_wr;
        end
        if (ang_wr) begin
            r_lk_index <= i_cfg_index;
            r_lk_neg_s <= wr_ang[ANGLE_BITS-1];
            r_lk_neg_c <= wr_ang_c[ANGLE_BITS-1];
            r_lk_sin   <= SIN_TAB[addr_s];
            r_lk_cos   <= SIN_TAB[addr_c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sin_x    <= '0;
            r_cfg.cos_x    <= 16'sd32767;
            r_cfg.sin_y    <= '0;
            r_cfg.cos_y    <= 16'sd32767;
            r_cfg.sin_z    <= '0;
            r_cfg.cos_z    <= 16'sd32767;
            r_cfg.offset_x <= '0;
            r_cfg.offset_y <= '0;
            r_cfg.depth    <= '0;
        end else begin
            if (r_lk_valid) begin
                unique case (r_lk_index)
                    CFG_ANGLE_X: begin
                        r_cfg.sin_x <= lk_sin;
                        r_cfg.cos_x <= lk_cos;
                    end
                    CFG_ANGLE_Y: begin
                        r_cfg.sin_y <= lk_sin;
                        r_cfg.cos_y <= lk_cos;
                    end
                    CFG_ANGLE_Z: begin
                        r_cfg.sin_z <= lk_sin;
                        r_cfg.cos_z <= lk_cos;
                    end
                    default: begin
                    end
                endcase
            end
            if (cfg_wr) begin
                unique case (i_cfg_index)
                    CFG_OFFSET_X: r_cfg.offset_x <= i_cfg_data;
                    CFG_OFFSET_Y: r_cfg.offset_y <= i_cfg_data;
                    CFG_DEPTH:    r_cfg.depth    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    vrp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .i_q_full (q_stat.full),
        .o_busy   (busy),
        .o_push   (push),
        .o_item   (f_item)
    );

    vrp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    vrp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .i_cfg   (r_cfg),
        .o_valid (o_res_valid),
        .o_res   (o_res)
    );

    `VRP_ASSERT_IMPL(a_queue_shallow, 1'b1, q_stat.count <= 2'd1, "queue backed up")
    `VRP_ASSERT_IMPL(a_face, o_res_valid && o_res.facing, !o_res.rotated_depth[15], "bad facing")
    `VRP_ASSERT_NEXT(a_push_drains, push, q_valid, "pushed beat not presented")
endmodule
`default_nettype wire

// ===== hw/rtl/vrp_front.sv =====
// Front end: takes command beats, recentres vertices and holds one item.
// Depends on vrp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vrp_front import vrp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_in   i_cmd,
    input  wire logic  i_q_full,
    output logic       o_busy,
    output logic       o_push,
    output t_item      o_item
);
    logic  r_valid, n_valid;
    t_item r_item, n_item;
    logic  accept;

    assign o_busy = r_valid & i_q_full;
    assign accept = i_start & ~o_busy;
    assign o_push = r_valid & ~i_q_full;
    assign o_item = r_item;

    always_comb begin
        n_item.op = i_cmd.opcode;
        n_item.x  = 17'(i_cmd.point_x);
        n_item.y  = 17'(i_cmd.point_y);
        n_item.z  = 17'(i_cmd.point_z);
        if (i_cmd.opcode == OP_VERTEX) begin
            n_item.x = 17'(i_cmd.point_x) - RECENTRE;
            n_item.y = 17'(i_cmd.point_y) - RECENTRE;
            n_item.z = 17'(i_cmd.point_z) - RECENTRE;
        end
        n_valid = accept | (r_valid & i_q_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (accept) begin
            r_item <= n_item;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/vrp_queue.sv =====
// Short item queue between the front end and the transform pipeline.
// Depends on vrp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vrp_queue import vrp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_valid,
    output t_item      o_item,
    output t_qstat     o_stat
);
    t_item      r_mem [QUEUE_DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign o_valid     = r_count != 2'd0;
    assign o_item      = r_mem[r_rp];
    assign pop         = o_valid;
    assign o_stat.full = r_count == 2'(QUEUE_DEPTH);
    assign o_stat.count = r_count;

    always_comb begin
        n_count = r_count + 2'(i_push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_count <= n_count;
        end
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/vrp_back.sv =====
// Transform pipeline: three rotations, perspective numerators, restoring divide.
// Depends on vrp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vrp_back import vrp_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output logic       o_valid,
    output t_out       o_res
);
    localparam int QB = QUOT_BITS;

    logic r_v [1:7];
    logic r_op [1:7];

    logic signed [16:0] r1_x;
    logic signed [32:0] r1_p0, r1_p1, r1_p2, r1_p3;
    logic signed [16:0] r2_x;
    logic signed [17:0] r2_y1, r2_z1;
    logic signed [33:0] r3_p0, r3_p1, r3_p2, r3_p3;
    logic signed [17:0] r3_y1, r4_y1;
    logic signed [17:0] r4_x2, r4_z2;
    logic signed [33:0] r5_p0, r5_p1, r5_p2, r5_p3;
    logic signed [17:0] r5_z2, r6_z2, r7_z2;
    logic [19:0]        r5_pz, r6_pz, r7_pz;
    logic signed [18:0] r6_x3, r6_y3;
    logic signed [36:0] r7_ox, r7_oy;
    logic signed [41:0] r7_kx, r7_ky;

    logic signed [20:0] pz_sum;
    logic signed [41:0] num_x, num_y;
    logic signed [41:0] mag_x, mag_y;

    // divide lanes
    logic               r_dv   [0:QB];
    logic               r_dop  [0:QB];
    logic               r_dnx  [0:QB];
    logic               r_dny  [0:QB];
    logic [19:0]        r_dpz  [0:QB];
    logic signed [17:0] r_dz2  [0:QB];
    logic [33:0]        r_remx [0:QB];
    logic [33:0]        r_remy [0:QB];
    logic [QB-1:0]      r_qx   [0:QB];
    logic [QB-1:0]      r_qy   [0:QB];
    logic [33:0]        n_remx [0:QB-1];
    logic [33:0]        n_remy [0:QB-1];
    logic [QB-1:0]      n_qx   [0:QB-1];
    logic [QB-1:0]      n_qy   [0:QB-1];

    logic               r_ov;
    t_out               r_res;
    logic signed [16:0] px, py;

    always_comb begin
        pz_sum = 21'(r4_z2) + 21'(i_cfg.depth) + PERSP_Q88;
        if (pz_sum <= MIN_DEPTH) begin
            pz_sum = MIN_DEPTH;
        end
        num_x = 42'(r7_ox) + r7_kx;
        num_y = 42'(r7_oy) + r7_ky;
        mag_x = num_x[41] ? -num_x : num_x;
        mag_y = num_y[41] ? -num_y : num_y;
    end

    always_comb begin
        for (int d = 0; d < QB; d++) begin
            logic [35:0] trial;
            trial     = 36'(r_dpz[d]) << (QB - 1 - d);
            n_remx[d] = r_remx[d];
            n_remy[d] = r_remy[d];
            n_qx[d]   = r_qx[d];
            n_qy[d]   = r_qy[d];
            if (36'(r_remx[d]) >= trial) begin
                n_remx[d] = 34'(36'(r_remx[d]) - trial);
                n_qx[d][QB-1-d] = 1'b1;
            end
            if (36'(r_remy[d]) >= trial) begin
                n_remy[d] = 34'(36'(r_remy[d]) - trial);
                n_qy[d][QB-1-d] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= 7; s++) begin
                r_v[s] <= 1'b0;
            end
            for (int d = 0; d <= QB; d++) begin
                r_dv[d] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else begin
            r_v[1] <= i_valid;
            for (int s = 2; s <= 7; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_dv[0] <= r_v[7];
            for (int d = 1; d <= QB; d++) begin
                r_dv[d] <= r_dv[d-1];
            end
            r_ov <= r_dv[QB];
        end

        r_op[1] <= i_item.op;
        for (int s = 2; s <= 7; s++) begin
            r_op[s] <= r_op[s-1];
        end

        // rotate about x
        r1_x  <= i_item.x;
        r1_p0 <= i_item.y * i_cfg.cos_x;
        r1_p1 <= i_item.z * i_cfg.sin_x;
        r1_p2 <= i_item.y * i_cfg.sin_x;
        r1_p3 <= i_item.z * i_cfg.cos_x;
        r2_x  <= r1_x;
        r2_y1 <= 18'((r1_p0 - r1_p1) >>> 15);
        r2_z1 <= 18'((r1_p2 + r1_p3) >>> 15);
        // rotate about y
        r3_p0 <= r2_x * i_cfg.cos_y;
        r3_p1 <= r2_z1 * i_cfg.sin_y;
        r3_p2 <= r2_z1 * i_cfg.cos_y;
        r3_p3 <= r2_x * i_cfg.sin_y;
        r3_y1 <= r2_y1;
        r4_x2 <= 18'((r3_p0 + r3_p1) >>> 15);
        r4_z2 <= 18'((r3_p2 - r3_p3) >>> 15);
        r4_y1 <= r3_y1;
        // rotate about z, form depth
        r5_p0 <= r4_x2 * i_cfg.cos_z;
        r5_p1 <= r4_y1 * i_cfg.sin_z;
        r5_p2 <= r4_x2 * i_cfg.sin_z;
        r5_p3 <= r4_y1 * i_cfg.cos_z;
        r5_z2 <= r4_z2;
        r5_pz <= 20'(pz_sum);
        r6_x3 <= 19'((r5_p0 - r5_p1) >>> 15);
        r6_y3 <= 19'((r5_p2 + r5_p3) >>> 15);
        r6_z2 <= r5_z2;
        r6_pz <= r5_pz;
        // numerators
        r7_ox <= i_cfg.offset_x * $signed({1'b0, r6_pz});
        r7_oy <= i_cfg.offset_y * $signed({1'b0, r6_pz});
        r7_kx <= r6_x3 * PROJ_SCALE;
        r7_ky <= r6_y3 * PROJ_SCALE;
        r7_z2 <= r6_z2;
        r7_pz <= r6_pz;

        r_dop[0]  <= r_op[7];
        r_dnx[0]  <= num_x[41];
        r_dny[0]  <= num_y[41];
        r_remx[0] <= mag_x[41:8];
        r_remy[0] <= mag_y[41:8];
        r_qx[0]   <= '0;
        r_qy[0]   <= '0;
        r_dpz[0]  <= r7_pz;
        r_dz2[0]  <= r7_z2;
        for (int d = 0; d < QB; d++) begin
            r_dop[d+1]  <= r_dop[d];
            r_dnx[d+1]  <= r_dnx[d];
            r_dny[d+1]  <= r_dny[d];
            r_dpz[d+1]  <= r_dpz[d];
            r_dz2[d+1]  <= r_dz2[d];
            r_remx[d+1] <= n_remx[d];
            r_remy[d+1] <= n_remy[d];
            r_qx[d+1]   <= n_qx[d];
            r_qy[d+1]   <= n_qy[d];
        end

        if (r_dop[QB] == OP_VERTEX) begin
            r_res.pixel_x <= f_sat16(20'(px) + CENTRE_X);
            r_res.pixel_y <= f_sat16(20'(py) + CENTRE_Y);
        end else begin
            r_res.pixel_x <= '0;
            r_res.pixel_y <= '0;
        end
        r_res.rotated_depth <= f_sat16(20'(r_dz2[QB]));
        r_res.facing        <= r_dz2[QB] > 18'sd0;
    end

    always_comb begin
        px = r_dnx[QB] ? -$signed({1'b0, r_qx[QB]}) : $signed({1'b0, r_qx[QB]});
        py = r_dny[QB] ? -$signed({1'b0, r_qy[QB]}) : $signed({1'b0, r_qy[QB]});
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;
endmodule
`default_nettype wire

// ===== dv/vertex_rotate_project_core_test.sv =====
// Self-checking testbench for vertex_rotate_project_core: directed and random points
// through several rotation and projection settings, checked against an in-bench predictor.
// Depends on vrp_pkg and the RTL of the core.
`timescale 1ns / 1ps
module vertex_rotate_project_core_test;
    import vrp_pkg::*;

    localparam int          LATENCY     = 26;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [2:0]  CFG_SPARE_6 = 3'd6;
    localparam logic [2:0]  CFG_SPARE_7 = 3'd7;
    localparam longint unsigned HALF_PI_Q60 = 64'h1921FB54442D1847;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in         i_cmd = '0;
    logic        o_res_valid;
    t_out        o_res;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    logic [11:0]        ang_x, ang_y, ang_z;
    logic signed [15:0] off_x, off_y, depth_off;
    t_out               pending_q[$];
    int                 errors = 0;
    int                 cycles = 0;
    bit                 allow_idle = 1'b1;

    vertex_rotate_project_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("vertex_rotate_project_core_test: errors");
            $finish;
        end
    end

    function automatic longint unsigned mul_q60(longint unsigned a, longint unsigned b);
        longint unsigned ah, al, bh, bl;
        ah = a >> 32; al = a & 64'hFFFFFFFF;
        bh = b >> 32; bl = b & 64'hFFFFFFFF;
        return ((ah * bh) << 4) + ((ah * bl + al * bh) >> 28) + ((al * bl) >> 60);
    endfunction

    function automatic longint sine_q15(logic [11:0] k);
        longint unsigned r, x, x2, term, sum, val;
        int q;
        q = k[11:10];
        r = k[9:0];
        if (q[0]) r = 1024 - r;
        x = (HALF_PI_Q60 >> 10) * r;
        x2 = mul_q60(x, x);
        term = x;
        sum = x;
        for (int n = 1; n <= 13; n++) begin
            term = mul_q60(term, x2) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum = sum - term;
            else sum = sum + term;
        end
        val = ((sum >> 20) * 32767 + (64'd1 << 39)) >> 40;
        return (q >= 2) ? -longint'(val) : longint'(val);
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic t_out predict_point(t_in p);
        longint x, y, z, sx, cx, sy, cy, sz, cz, y1, z1, x2, z2, x3, y3, pz, den;
        t_out r;
        x = p.point_x; y = p.point_y; z = p.point_z;
        sx = sine_q15(ang_x); cx = sine_q15(ang_x + 12'd1024);
        sy = sine_q15(ang_y); cy = sine_q15(ang_y + 12'd1024);
        sz = sine_q15(ang_z); cz = sine_q15(ang_z + 12'd1024);
        if (p.opcode == OP_VERTEX) begin
            x -= 384; y -= 384; z -= 384;
        end
        y1 = (y * cx - z * sx) >>> 15;
        z1 = (y * sx + z * cx) >>> 15;
        x2 = (x * cy + z1 * sy) >>> 15;
        z2 = (z1 * cy - x * sy) >>> 15;
        x3 = (x2 * cz - y1 * sz) >>> 15;
        y3 = (x2 * sz + y1 * cz) >>> 15;
        if (p.opcode == OP_NORMAL) begin
            r.pixel_x = '0;
            r.pixel_y = '0;
        end else begin
            pz = z2 + longint'(depth_off) + 204800;
            if (pz <= 26) pz = 26;
            den = pz * 256;
            r.pixel_x = clip16((longint'(off_x) * pz + x3 * 1638400) / den + 50);
            r.pixel_y = clip16((longint'(off_y) * pz + y3 * 1638400) / den + 20);
        end
        r.rotated_depth = clip16(z2);
        r.facing = (z2 > 0);
        return r;
    endfunction

    always @(negedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", o_res);
            end else begin
                t_out e;
                e = pending_q.pop_front();
                if (o_res.pixel_x !== e.pixel_x || o_res.pixel_y !== e.pixel_y ||
                    o_res.rotated_depth !== e.rotated_depth || o_res.facing !== e.facing) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp px=%0d py=%0d z=%0d f=%0b ",
                                  "got px=%0d py=%0d z=%0d f=%0b"},
                                 e.pixel_x, e.pixel_y, e.rotated_depth, e.facing,
                                 o_res.pixel_x, o_res.pixel_y, o_res.rotated_depth,
                                 o_res.facing);
                end
            end
        end
    end

    task automatic send_point(t_in p);
        bit acc;
        if (allow_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= p;
        do begin
            @(negedge i_clk);
            acc = !busy;
            if (acc) pending_q.push_back(predict_point(p));
            @(posedge i_clk);
        end while (!acc);
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] data);
        bit acc;
        if (allow_idle && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            acc = o_cfg_ready;
            @(posedge i_clk);
        end while (!acc);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ANGLE_X:  ang_x = data[11:0];
            CFG_ANGLE_Y:  ang_y = data[11:0];
            CFG_ANGLE_Z:  ang_z = data[11:0];
            CFG_OFFSET_X: off_x = data;
            CFG_OFFSET_Y: off_y = data;
            CFG_DEPTH:    depth_off = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in make_point(logic op, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        t_in p;
        p.opcode = op; p.point_x = x; p.point_y = y; p.point_z = z;
        return p;
    endfunction

    task automatic set_all(logic [11:0] ax, logic [11:0] ay, logic [11:0] az,
                           logic [15:0] ox, logic [15:0] oy, logic [15:0] dz);
        write_reg(CFG_ANGLE_X, {4'($urandom), ax});
        write_reg(CFG_ANGLE_Y, {4'($urandom), ay});
        write_reg(CFG_ANGLE_Z, {4'($urandom), az});
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_DEPTH, dz);
    endtask

    task automatic test_reset_settings;
        send_point(make_point(OP_VERTEX, 16'h0180, 16'h0180, 16'h0180));
        send_point(make_point(OP_VERTEX, 16'h7fff, 16'h8000, 16'h0000));
        send_point(make_point(OP_NORMAL, 16'h0000, 16'h0000, 16'h0001));
        send_point(make_point(OP_NORMAL, 16'h0000, 16'h0000, 16'hffff));
        drain();
    endtask

    task automatic test_directed;
        set_all(12'd512, 12'd512, 12'd0, 16'h7fff, 16'h8000, 16'h8000);
        send_point(make_point(OP_VERTEX, 16'h7fff, 16'h7fff, 16'h7fff));
        send_point(make_point(OP_VERTEX, 16'h8000, 16'h8000, 16'h8000));
        send_point(make_point(OP_NORMAL, 16'h7fff, 16'h7fff, 16'h7fff));
        send_point(make_point(OP_NORMAL, 16'h8000, 16'h8000, 16'h8000));
        drain();
        set_all(12'd4095, 12'd1024, 12'd3072, 16'h8000, 16'h7fff, 16'h7fff);
        write_reg(CFG_SPARE_6, 16'hffff);
        write_reg(CFG_SPARE_7, 16'h1234);
        send_point(make_point(OP_VERTEX, 16'h8000, 16'h7fff, 16'h8000));
        send_point(make_point(OP_VERTEX, 16'h0000, 16'h0000, 16'h0000));
        send_point(make_point(OP_NORMAL, 16'h7fff, 16'h8000, 16'h0000));
        send_point(make_point(OP_VERTEX, 16'hffff, 16'hffff, 16'hffff));
        drain();
        set_all(12'd2048, 12'd0, 12'd2048, 16'h0000, 16'h0000, 16'h0000);
        send_point(make_point(OP_VERTEX, 16'h4000, 16'hc000, 16'h7fff));
        send_point(make_point(OP_NORMAL, 16'h0001, 16'h0001, 16'h0001));
        drain();
    endtask

    task automatic test_random;
        for (int ph = 0; ph < 9; ph++) begin
            allow_idle = (ph < 7);
            if (ph == 0) set_all(12'd0, 12'd0, 12'd0, 16'h0000, 16'h0000, 16'h0000);
            else if (ph == 1) set_all(12'd4095, 12'd4095, 12'd4095, 16'h7fff, 16'h7fff, 16'h7fff);
            else if (ph == 2) set_all(12'd0, 12'd0, 12'd0, 16'h8000, 16'h8000, 16'h8000);
            else set_all(12'($urandom), 12'($urandom), 12'($urandom), pick16(), pick16(), pick16());
            for (int i = 0; i < 50; i++)
                send_point(make_point(1'($urandom), pick16(), pick16(), pick16()));
            drain();
        end
    endtask

    initial begin
        ang_x = '0; ang_y = '0; ang_z = '0;
        off_x = '0; off_y = '0; depth_off = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_settings();
        test_directed();
        test_random();
        if (errors == 0 && pending_q.size() == 0) begin
            $display("vertex_rotate_project_core_test: clean");
        end else begin
            $display("vertex_rotate_project_core_test: errors");
        end
        $finish;
    end
endmodule
